### hw/rtl/fcsg_pkg.sv
// Package for the filled circle span generator: item and state types, slot count,
// mode codes and default screen size. No dependencies.
`timescale 1ns / 1ps

package fcsg_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 200;

    localparam int SLOTS    = 4;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int COORD_W  = 14;
    localparam int STEP_W   = 11;
    localparam int DEC_W    = 16;
    localparam int DSUM_W   = 18;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [11:0] center_x;
        logic signed [11:0] center_y;
        logic [9:0]         radius;
        logic [7:0]         color;
    } t_in_item;

    typedef struct packed {
        logic       span_valid;
        logic [7:0] row;
        logic [8:0] start_col;
        logic [8:0] end_col;
        logic [7:0] fill_color;
        logic       last;
        logic       done_res;
    } t_out_item;

    typedef struct packed {
        logic [STEP_W-1:0]       step_x;
        logic [STEP_W-1:0]       step_y;
        logic signed [DEC_W-1:0] decision;
        logic signed [11:0]      centre_col;
        logic signed [11:0]      centre_row;
        logic [7:0]              held_color;
        logic                    active;
    } t_circle_state;

    typedef struct packed {
        logic [SLOTS-1:0]      mask;
        t_out_item [SLOTS-1:0] entry;
    } t_batch;

endpackage

### hw/rtl/fcsg_span_calc.sv
// One transfer: a start sets the circle state, an advance runs one midpoint
// step (four clamped spans); gives next state and batch. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_span_calc
    import fcsg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  t_in_item      i_item,
    input  t_circle_state i_state,
    output t_circle_state o_state_next,
    output t_batch        o_batch
);

    localparam logic signed [COORD_W-1:0] COL_MAX = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] ROW_LIM = COORD_W'(SCREEN_HEIGHT);

    logic signed [COORD_W-1:0] cc;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] half [SLOTS];
    logic signed [COORD_W-1:0] rowv [SLOTS];
    logic signed [COORD_W-1:0] scol [SLOTS];
    logic signed [COORD_W-1:0] ecol [SLOTS];
    logic [SLOTS-1:0]          vis;
    logic [SLOTS-1:0]          lastv;
    logic                      higher;
    logic signed [DSUM_W-1:0]  d_ext;
    logic signed [DSUM_W-1:0]  d_next;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_next;
    logic                      done;
    t_out_item                 null_item;

    always_comb begin
        cc = COORD_W'(i_state.centre_col);
        cr = COORD_W'(i_state.centre_row);
        xs = signed'(COORD_W'(i_state.step_x));
        ys = signed'(COORD_W'(i_state.step_y));

        half[0] = xs;
        half[1] = xs;
        half[2] = ys;
        half[3] = ys;
        rowv[0] = cr + ys;
        rowv[1] = cr - ys;
        rowv[2] = cr + xs;
        rowv[3] = cr - xs;

        for (int k = 0; k < SLOTS; k++) begin
            scol[k] = cc - half[k];
            ecol[k] = cc + half[k];
            if (scol[k] < 0) begin
                scol[k] = '0;
            end
            if (ecol[k] > COL_MAX) begin
                ecol[k] = COL_MAX;
            end
            vis[k] = (rowv[k] >= 0) && (rowv[k] < ROW_LIM) && (scol[k] <= ecol[k]);
        end

        higher = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            lastv[k] = vis[k] && !higher;
            higher   = higher | vis[k];
        end

        d_ext = DSUM_W'(i_state.decision);
        if (i_state.decision < 0) begin
            d_next = d_ext + DSUM_W'(xs <<< 2) + DSUM_W'(6);
            y_next = ys;
        end else begin
            d_next = d_ext + DSUM_W'((xs - ys) <<< 2) + DSUM_W'(10);
            y_next = ys - COORD_W'(1);
        end
        x_next = xs + COORD_W'(1);
        done   = x_next > y_next;

        null_item            = '0;
        null_item.fill_color = i_state.held_color;
        null_item.last       = 1'b1;
        null_item.done_res   = 1'b1;

        o_state_next = i_state;
        o_batch      = '0;

        if (i_item.mode == MODE_START) begin
            o_state_next.step_x     = '0;
            o_state_next.step_y     = STEP_W'(i_item.radius);
            o_state_next.decision   = DEC_W'(3) - DEC_W'({i_item.radius, 1'b0});
            o_state_next.centre_col = i_item.center_x;
            o_state_next.centre_row = i_item.center_y;
            o_state_next.held_color = i_item.color;
            o_state_next.active     = 1'b1;
            o_batch.mask            = SLOTS'(1);
            o_batch.entry[0]            = null_item;
            o_batch.entry[0].fill_color = i_item.color;
            o_batch.entry[0].done_res   = 1'b0;
        end else if (!i_state.active) begin
            o_batch.mask     = SLOTS'(1);
            o_batch.entry[0] = null_item;
        end else begin
            o_state_next.step_x   = x_next[STEP_W-1:0];
            o_state_next.step_y   = y_next[STEP_W-1:0];
            o_state_next.decision = d_next[DEC_W-1:0];
            o_state_next.active   = !done;
            for (int k = 0; k < SLOTS; k++) begin
                o_batch.entry[k].span_valid = 1'b1;
                o_batch.entry[k].row        = rowv[k][7:0];
                o_batch.entry[k].start_col  = scol[k][8:0];
                o_batch.entry[k].end_col    = ecol[k][8:0];
                o_batch.entry[k].fill_color = i_state.held_color;
                o_batch.entry[k].last       = lastv[k];
                o_batch.entry[k].done_res   = done;
            end
            o_batch.mask = vis;
            if (vis == '0) begin
                o_batch.mask              = SLOTS'(1);
                o_batch.entry[0]          = null_item;
                o_batch.entry[0].done_res = done;
            end
        end
    end

endmodule

### hw/rtl/fcsg_result_queue.sv
// Result register holding one batch of up to four results and handing them out
// one transfer per cycle while the output is not stalled, lowest slot first. Depends on fcsg_pkg.
`timescale 1ns / 1ps

module fcsg_result_queue
    import fcsg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_batch    i_batch,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic [SLOTS-1:0]      r_mask;
    logic [SLOTS-1:0]      n_mask;
    t_out_item [SLOTS-1:0] r_entry;
    logic [SLOTS-1:0]      sel;
    logic [SLOTS-1:0]      rest;
    logic [SLOT_W-1:0]     idx;
    logic                  fire;

    always_comb begin
        sel  = r_mask & (~r_mask + SLOTS'(1));
        rest = r_mask & ~sel;
        idx  = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (sel[k]) begin
                idx = SLOT_W'(k);
            end
        end
        o_out_valid = |r_mask;
        o_out_item  = r_entry[idx];
        fire        = o_out_valid && !i_out_stall;
        o_free      = !o_out_valid || (fire && (rest == '0));

        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_batch.mask;
        end else if (fire) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_batch.entry;
        end
    end

endmodule

### hw/rtl/filled_circle_span_generator_unit.sv
// Top level of the filled circle span generator: input register, circle state,
// span calculation and result queue. Depends on fcsg_pkg, fcsg_span_calc and
// fcsg_result_queue.
//
// A start transfer (mode 0) loads centre, radius and colour and yields one status
// result; each advance transfer (mode 1) runs one midpoint step and yields one to
// four results, the final one marked by last. The first result of an item comes
// out once the item has passed the input register and been loaded into the result
// queue, which sends one result per cycle while the output is not stalled; a start,
// an idle advance or a step with every span dropped has one result, and a step with
// four visible spans has four. The input register takes a new item every cycle while
// the queue keeps up, and holds one item while the queue drains.
`timescale 1ns / 1ps

module filled_circle_span_generator_unit
    import fcsg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic          r_in_valid;
    logic          n_in_valid;
    t_in_item      r_in_item;
    t_circle_state r_state;
    t_circle_state state_next;
    t_batch        batch;
    logic          q_free;
    logic          batch_load;
    logic          in_fire;

    assign batch_load = r_in_valid && q_free;
    assign o_in_stall = r_in_valid && !q_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (batch_load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (batch_load) begin
                r_state <= state_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
    end

    fcsg_span_calc #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_calc (
        .i_item       (r_in_item),
        .i_state      (r_state),
        .o_state_next (state_next),
        .o_batch      (batch)
    );

    fcsg_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (batch_load),
        .i_batch     (batch),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_null_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.span_valid |-> o_out_item.last)
        else $error("result without a span is not the last of its item");

    a_batch_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last && !i_out_stall |=> o_out_valid)
        else $error("item results ended before last");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |-> !r_state.active)
        else $error("done result while circle still active");

    a_span_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.span_valid |-> o_out_item.fill_color == r_state.held_color)
        else $error("span color differs from held color");

endmodule
